FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the crop filter RTL, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/prcf_pkg.sv
// ----------------------------------------------------------------------------
// prcf_pkg
// Shared types and constants of the point region crop filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prcf_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int REG_IDX_W       = 3;
    // half width / radius reset value: 0.5 in Q16.16
    localparam logic [47:0] SIZE_RESET = 48'd32768;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MODE     = 3'd0,
        REG_CENTER_X = 3'd1,
        REG_CENTER_Y = 3'd2,
        REG_CENTER_Z = 3'd3,
        REG_SIZE_X   = 3'd4,
        REG_SIZE_Y   = 3'd5,
        REG_SIZE_Z   = 3'd6
    } t_reg_idx;

    typedef enum logic {
        MODE_SPHERE = 1'b0,
        MODE_BOX    = 1'b1
    } t_region_mode;

    // load enables of the two register ranks of a squaring unit
    typedef struct packed {
        logic en_a;
        logic en_b;
    } t_sq_ctl;

endpackage

FILE: hdl/prcf_if.sv
// ----------------------------------------------------------------------------
// prcf_if
// Valid/ready channels of the crop filter: points in, results out, and the
// register write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface prcf_point_if
    import prcf_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          point_invalid;
    logic                          cloud_end;

    modport source (output valid, point_x, point_y, point_z, point_invalid, cloud_end,
                    input ready);
    modport sink   (input valid, point_x, point_y, point_z, point_invalid, cloud_end,
                    output ready);
endinterface

interface prcf_result_if
    import prcf_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          keep;
    logic                          out_end;

    modport source (output valid, out_x, out_y, out_z, keep, out_end, input ready);
    modport sink   (input valid, out_x, out_y, out_z, keep, out_end, output ready);
endinterface

interface prcf_cfg_if
    import prcf_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [REG_IDX_W-1:0]   index;
    logic [COORD_WIDTH-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/prcf_square.sv
// ----------------------------------------------------------------------------
// prcf_square
// Exact unsigned square over two register ranks: half-width partial
// products, then their weighted sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prcf_square
    import prcf_pkg::*;
#(
    parameter int VAL_W = COORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  t_sq_ctl            i_ctl,
    input  logic [VAL_W-1:0]   i_val,
    output logic [2*VAL_W-1:0] o_sq
);

    localparam int LoW = (VAL_W + 1) / 2;
    localparam int HiW = VAL_W - LoW;
    localparam int SqW = 2 * VAL_W;

    logic [LoW-1:0]   w_lo;
    logic [HiW-1:0]   w_hi;
    logic [2*LoW-1:0] n_ll;
    logic [VAL_W-1:0] n_lh;
    logic [2*HiW-1:0] n_hh;
    logic [2*LoW-1:0] r_ll;
    logic [VAL_W-1:0] r_lh;
    logic [2*HiW-1:0] r_hh;
    logic [SqW-1:0]   n_sq;
    logic [SqW-1:0]   r_sq;

    assign w_lo = i_val[LoW-1:0];
    assign w_hi = i_val[VAL_W-1:LoW];

    assign n_ll = w_lo * w_lo;
    assign n_lh = w_hi * w_lo;
    assign n_hh = w_hi * w_hi;

    // hi^2 * 2^2L + 2 * hi * lo * 2^L + lo^2
    assign n_sq = (SqW'(r_hh) << (2 * LoW)) + (SqW'(r_lh) << (LoW + 1)) + SqW'(r_ll);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_a) begin
            r_ll <= n_ll;
            r_lh <= n_lh;
            r_hh <= n_hh;
        end
        if (i_ctl.en_b) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

FILE: hdl/point_region_crop_filter.sv
// ----------------------------------------------------------------------------
// point_region_crop_filter
// Sphere / box crop test for a stream of 3-D points in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   i_pt    point channel; one point per transfer, with a not-a-number flag
//           and an end-of-cloud mark.
//   o_res   result channel; the point passed through unchanged, a keep flag
//           and the copied end mark. Exactly one result per point, in order.
//   i_cfg   register writes (mode, centre, sizes); always ready. Write only
//           while no point is in flight.
// Pipeline: an input transfer passes the registered ranks offset, partial products,
//   squares and compare before its result shows on o_res. Throughput: one point
//   per cycle unless o_res stalls; the rate is set by the pipelined squaring units.
// Each stage holds its own valid bit and advances whenever the stage after
// it is empty or moving, so bubbles close up while o_res is stalled and
// i_pt stays ready until all four stages are full.
// Reset empties the pipeline and loads sphere mode, centre at the origin
// and all sizes at 0.5.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_region_crop_filter
    import prcf_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    prcf_cfg_if.sink       i_cfg,
    prcf_point_if.sink     i_pt,
    prcf_result_if.source  o_res
);

`include "assert_macros.svh"

    localparam int CW   = COORD_WIDTH;
    localparam int SW   = COORD_WIDTH - 1;        // size register width
    localparam int SumW = 2 * COORD_WIDTH + 2;    // three squares of CW-bit offsets

    localparam logic [SW-1:0] SizeReset = SIZE_RESET[SW-1:0];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_region_mode         r_mode;
    logic signed [CW-1:0] r_center_x;
    logic signed [CW-1:0] r_center_y;
    logic signed [CW-1:0] r_center_z;
    logic [SW-1:0]        r_size_x;
    logic [SW-1:0]        r_size_y;
    logic [SW-1:0]        r_size_z;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_SPHERE;
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_size_x   <= SizeReset;
            r_size_y   <= SizeReset;
            r_size_z   <= SizeReset;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_MODE:     r_mode     <= t_region_mode'(i_cfg.data[0]);
                REG_CENTER_X: r_center_x <= i_cfg.data;
                REG_CENTER_Y: r_center_y <= i_cfg.data;
                REG_CENTER_Z: r_center_z <= i_cfg.data;
                REG_SIZE_X:   r_size_x   <= i_cfg.data[SW-1:0];
                REG_SIZE_Y:   r_size_y   <= i_cfg.data[SW-1:0];
                REG_SIZE_Z:   r_size_z   <= i_cfg.data[SW-1:0];
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage advance: each stage loads when it is empty or drains
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_ov;
    logic w_en1, w_en2, w_en3, w_en4;

    assign w_en4 = !r_ov || o_res.ready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;

    assign i_pt.ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_pt.valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_ov <= r_v3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the point and its absolute offsets from the centre.
    // Flipping the sign bit gives an order-preserving unsigned code, so the
    // offset is one compare and one subtract with no overflow.
    // ------------------------------------------------------------------
    function automatic logic [CW-1:0] abs_offset(input logic [CW-1:0] p,
                                                 input logic [CW-1:0] c);
        logic [CW-1:0] a;
        logic [CW-1:0] b;
        a = {~p[CW-1], p[CW-2:0]};
        b = {~c[CW-1], c[CW-2:0]};
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    logic signed [CW-1:0] r_s1_x, r_s1_y, r_s1_z;
    logic                 r_s1_inv, r_s1_end;
    logic [CW-1:0]        r_s1_dx, r_s1_dy, r_s1_dz;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_x   <= i_pt.point_x;
            r_s1_y   <= i_pt.point_y;
            r_s1_z   <= i_pt.point_z;
            r_s1_inv <= i_pt.point_invalid;
            r_s1_end <= i_pt.cloud_end;
            r_s1_dx  <= abs_offset(i_pt.point_x, r_center_x);
            r_s1_dy  <= abs_offset(i_pt.point_y, r_center_y);
            r_s1_dz  <= abs_offset(i_pt.point_z, r_center_z);
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 and 3: squares of the offsets and of the radius run in the
    // squaring units; the box test and the point travel alongside.
    // ------------------------------------------------------------------
    t_sq_ctl w_sq_ctl;

    assign w_sq_ctl.en_a = w_en2;
    assign w_sq_ctl.en_b = w_en3;

    logic [2*CW-1:0] w_sq_x, w_sq_y, w_sq_z;
    logic [2*SW-1:0] w_sq_r;

    prcf_square #(.VAL_W(CW)) u_sq_x (
        .i_clk (i_clk), .i_ctl (w_sq_ctl), .i_val (r_s1_dx), .o_sq (w_sq_x)
    );
    prcf_square #(.VAL_W(CW)) u_sq_y (
        .i_clk (i_clk), .i_ctl (w_sq_ctl), .i_val (r_s1_dy), .o_sq (w_sq_y)
    );
    prcf_square #(.VAL_W(CW)) u_sq_z (
        .i_clk (i_clk), .i_ctl (w_sq_ctl), .i_val (r_s1_dz), .o_sq (w_sq_z)
    );
    prcf_square #(.VAL_W(SW)) u_sq_r (
        .i_clk (i_clk), .i_ctl (w_sq_ctl), .i_val (r_size_x), .o_sq (w_sq_r)
    );

    logic signed [CW-1:0] r_s2_x, r_s2_y, r_s2_z;
    logic                 r_s2_inv, r_s2_end, r_s2_box;
    logic signed [CW-1:0] r_s3_x, r_s3_y, r_s3_z;
    logic                 r_s3_inv, r_s3_end, r_s3_box;
    logic                 n_box;

    // box: every offset strictly below its half width
    assign n_box = (r_s1_dx < CW'(r_size_x)) && (r_s1_dy < CW'(r_size_y))
                && (r_s1_dz < CW'(r_size_z));

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_x   <= r_s1_x;
            r_s2_y   <= r_s1_y;
            r_s2_z   <= r_s1_z;
            r_s2_inv <= r_s1_inv;
            r_s2_end <= r_s1_end;
            r_s2_box <= n_box;
        end
        if (w_en3) begin
            r_s3_x   <= r_s2_x;
            r_s3_y   <= r_s2_y;
            r_s3_z   <= r_s2_z;
            r_s3_inv <= r_s2_inv;
            r_s3_end <= r_s2_end;
            r_s3_box <= r_s2_box;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sum the squares, compare against radius squared, pick the
    // region test by mode and drop invalid points into the result register.
    // ------------------------------------------------------------------
    logic [SumW-1:0] n_d2;
    logic            n_sphere;
    logic            n_keep;

    assign n_d2     = SumW'(w_sq_x) + SumW'(w_sq_y) + SumW'(w_sq_z);
    assign n_sphere = n_d2 < SumW'(w_sq_r);
    assign n_keep   = !r_s3_inv && ((r_mode == MODE_BOX) ? r_s3_box : n_sphere);

    logic signed [CW-1:0] r_out_x, r_out_y, r_out_z;
    logic                 r_out_keep, r_out_end;

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_out_x    <= r_s3_x;
            r_out_y    <= r_s3_y;
            r_out_z    <= r_s3_z;
            r_out_keep <= n_keep;
            r_out_end  <= r_s3_end;
        end
    end

    assign o_res.valid   = r_ov;
    assign o_res.out_x   = r_out_x;
    assign o_res.out_y   = r_out_y;
    assign o_res.out_z   = r_out_z;
    assign o_res.keep    = r_out_keep;
    assign o_res.out_end = r_out_end;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an invalid point reaching the result register is never kept
    `ASSERT_NXT(a_invalid_dropped, r_v3 && r_s3_inv && w_en4, !o_res.keep)
    // a stalled result holds the last stage and its payload
    `ASSERT_NXT(a_stage3_holds, r_v3 && !w_en4, r_v3 && $stable(r_s3_x) && $stable(r_s3_box))
    // with an empty result register every stage can move, so input is ready
    `ASSERT_IMP(a_ready_when_empty, !o_res.valid, i_pt.ready)

endmodule
